FILE: rtl/core/touch_zone_key_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// Touch zone key mapper assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_ZONE_KEY_MAPPER_TOP_MACROS_SVH
`define TOUCH_ZONE_KEY_MAPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TZKM_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define TZKM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define TZKM_ASSERT(label, cond, msg)

`define TZKM_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

FILE: rtl/core/tzkm_pkg.sv
// ----------------------------------------------------------------------------
// Touch zone key mapper package
// Widths, codes, geometry constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tzkm_pkg;

    localparam int unsigned TZKM_QUEUE_DEPTH = 4;

    localparam int NUM_CTRL   = 7;
    localparam int NUM_RECT   = 4;
    localparam int FUNC_W     = 2;
    localparam int ID_W       = 16;
    localparam int X_W        = 13;
    localparam int Y_W        = 12;
    localparam int KEY_W      = 10;
    localparam int DZ_W       = 10;
    localparam int RAD_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIFF_W     = 14;
    localparam int MAG_W      = 13;
    localparam int SQ_W       = 26;
    localparam int SUM_W      = 27;

    localparam logic [FUNC_W-1:0] FUNC_DOWN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOTION = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UP     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_OTHER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DPAD_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_RADIUS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_RADIUS    = 2'd3;

    localparam logic [DZ_W-1:0]  DEAD_ZONE_RST   = 10'd160;
    localparam logic [RAD_W-1:0] DPAD_RADIUS_RST = 11'd688;
    localparam logic [RAD_W-1:0] A_RADIUS_RST    = 11'd432;
    localparam logic [RAD_W-1:0] B_RADIUS_RST    = 11'd368;

    localparam logic [KEY_W-1:0] KEY_A      = 10'h001;
    localparam logic [KEY_W-1:0] KEY_B      = 10'h002;
    localparam logic [KEY_W-1:0] KEY_SELECT = 10'h004;
    localparam logic [KEY_W-1:0] KEY_START  = 10'h008;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 10'h010;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 10'h020;
    localparam logic [KEY_W-1:0] KEY_UP     = 10'h040;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 10'h080;
    localparam logic [KEY_W-1:0] KEY_R      = 10'h100;
    localparam logic [KEY_W-1:0] KEY_L      = 10'h200;
    localparam logic [KEY_W-1:0] KEY_DPAD   = 10'h0F0;

    localparam int SLOT_DPAD   = 0;
    localparam int SLOT_A      = 1;
    localparam int SLOT_B      = 2;
    localparam int SLOT_RECT0  = 3;

    localparam logic [KEY_W-1:0] CTRL_KEY [NUM_CTRL] = '{
        KEY_DPAD, KEY_A, KEY_B, KEY_START, KEY_SELECT, KEY_L, KEY_R
    };

    // circle centers, 1/16 units
    localparam logic [X_W-1:0] DPAD_CX = 13'd864;
    localparam logic [Y_W-1:0] DPAD_CY = 12'd2944;
    localparam logic [X_W-1:0] A_CX    = 13'd5856;
    localparam logic [Y_W-1:0] A_CY    = 12'd2896;
    localparam logic [X_W-1:0] B_CX    = 13'd5120;
    localparam logic [Y_W-1:0] B_CY    = 12'd3232;

    // rectangles in order start, select, L, R; bounds inclusive, 1/16 units
    localparam logic [X_W-1:0] RECT_XLO [NUM_RECT] = '{13'd2960, 13'd1968, 13'd1216, 13'd4960};
    localparam logic [X_W-1:0] RECT_XHI [NUM_RECT] = '{13'd3856, 13'd2864, 13'd1856, 13'd5600};
    localparam logic [Y_W-1:0] RECT_YLO [NUM_RECT] = '{12'd3440, 12'd3440, 12'd224, 12'd224};
    localparam logic [Y_W-1:0] RECT_YHI [NUM_RECT] = '{12'd3760, 12'd3760, 12'd672, 12'd672};

    typedef struct packed {
        logic [DZ_W-1:0]  dead_zone;
        logic [RAD_W-1:0] dpad_radius;
        logic [RAD_W-1:0] a_radius;
        logic [RAD_W-1:0] b_radius;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     finger_id;
        logic                dpad_in;
        logic                a_in;
        logic                b_in;
        logic [KEY_W-1:0]    dir;
        logic [NUM_RECT-1:0] rect_hit;
    } evt_t;

    function automatic logic [MAG_W-1:0] abs_diff(input logic [DIFF_W-1:0] v,
                                                  input logic [DIFF_W-1:0] c);
        logic [DIFF_W-1:0] d;
        d = (v >= c) ? (v - c) : (c - v);
        return d[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tzkm_front.sv
// ----------------------------------------------------------------------------
// Touch zone key mapper front end
// Accepts events, squares the offsets, runs hit tests and d-pad direction.
// ----------------------------------------------------------------------------
`default_nettype none

module tzkm_front
    import tzkm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TZKM_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [ID_W-1:0]   finger_id,
    input  wire logic [X_W-1:0]    x_pos,
    input  wire logic [Y_W-1:0]    y_pos,
    input  wire cfg_t              cfg,
    input  wire logic [CNT_W-1:0]  q_count,
    output logic                   push,
    output evt_t                   push_data
);

    localparam int OCC_W = CNT_W + 1;

    logic [OCC_W-1:0] occupancy;
    logic             accept;

    logic [MAG_W-1:0] dmag_dx, dmag_dy, amag_dx, amag_dy, bmag_dx, bmag_dy;
    logic [DIFF_W-1:0] xe, ye;
    logic [KEY_W-1:0] dir_next;
    logic [NUM_RECT-1:0] rect_raw, rect_next;

    logic              s1_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [KEY_W-1:0]  dir_reg;
    logic [NUM_RECT-1:0] rect_reg;
    logic [SQ_W-1:0]   sq_ddx_reg, sq_ddy_reg, sq_adx_reg, sq_ady_reg, sq_bdx_reg, sq_bdy_reg;
    logic [SQ_W-1:0]   rsq_d_reg, rsq_a_reg, rsq_b_reg;

    logic [SUM_W-1:0]  sum_d, sum_a, sum_b;

    assign occupancy = {1'b0, q_count} + OCC_W'(s1_valid_reg);
    assign in_stall  = occupancy >= OCC_W'(QUEUE_DEPTH);
    assign accept    = in_valid && !in_stall;

    assign xe = DIFF_W'(x_pos);
    assign ye = DIFF_W'(y_pos);

    always_comb
    begin
        dmag_dx = abs_diff(xe, DIFF_W'(DPAD_CX));
        dmag_dy = abs_diff(ye, DIFF_W'(DPAD_CY));
        amag_dx = abs_diff(xe, DIFF_W'(A_CX));
        amag_dy = abs_diff(ye, DIFF_W'(A_CY));
        bmag_dx = abs_diff(xe, DIFF_W'(B_CX));
        bmag_dy = abs_diff(ye, DIFF_W'(B_CY));
    end

    always_comb
    begin
        dir_next = '0;
        if (dmag_dx > MAG_W'(cfg.dead_zone) || dmag_dy > MAG_W'(cfg.dead_zone))
        begin
            if (dmag_dx >= dmag_dy)
            begin
                dir_next = (x_pos < DPAD_CX) ? KEY_LEFT : KEY_RIGHT;
            end
            else
            begin
                dir_next = (y_pos < DPAD_CY) ? KEY_UP : KEY_DOWN;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_RECT; i++)
        begin
            rect_raw[i] = (x_pos >= RECT_XLO[i]) && (x_pos <= RECT_XHI[i]) &&
                          (y_pos >= RECT_YLO[i]) && (y_pos <= RECT_YHI[i]);
        end
        // first hit wins
        rect_next = rect_raw & ~(rect_raw - NUM_RECT'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            id_reg     <= finger_id;
            dir_reg    <= dir_next;
            rect_reg   <= rect_next;
            sq_ddx_reg <= SQ_W'(dmag_dx) * SQ_W'(dmag_dx);
            sq_ddy_reg <= SQ_W'(dmag_dy) * SQ_W'(dmag_dy);
            sq_adx_reg <= SQ_W'(amag_dx) * SQ_W'(amag_dx);
            sq_ady_reg <= SQ_W'(amag_dy) * SQ_W'(amag_dy);
            sq_bdx_reg <= SQ_W'(bmag_dx) * SQ_W'(bmag_dx);
            sq_bdy_reg <= SQ_W'(bmag_dy) * SQ_W'(bmag_dy);
            rsq_d_reg  <= SQ_W'(cfg.dpad_radius) * SQ_W'(cfg.dpad_radius);
            rsq_a_reg  <= SQ_W'(cfg.a_radius) * SQ_W'(cfg.a_radius);
            rsq_b_reg  <= SQ_W'(cfg.b_radius) * SQ_W'(cfg.b_radius);
        end
    end

    assign sum_d = SUM_W'(sq_ddx_reg) + SUM_W'(sq_ddy_reg);
    assign sum_a = SUM_W'(sq_adx_reg) + SUM_W'(sq_ady_reg);
    assign sum_b = SUM_W'(sq_bdx_reg) + SUM_W'(sq_bdy_reg);

    assign push = s1_valid_reg;

    always_comb
    begin
        push_data.func      = func_reg;
        push_data.finger_id = id_reg;
        push_data.dpad_in   = sum_d <= SUM_W'(rsq_d_reg);
        push_data.a_in      = sum_a <= SUM_W'(rsq_a_reg);
        push_data.b_in      = sum_b <= SUM_W'(rsq_b_reg);
        push_data.dir       = dir_reg;
        push_data.rect_hit  = rect_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/tzkm_queue.sv
// ----------------------------------------------------------------------------
// Touch zone key mapper event queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_zone_key_mapper_top_macros.svh"

module tzkm_queue
    import tzkm_pkg::*;
#(
    parameter int unsigned DEPTH = TZKM_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire evt_t             push_data,
    input  wire logic             pop,
    output evt_t                  pop_data,
    output logic [CNT_W-1:0]      count
);

    evt_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    `TZKM_ASSERT(a_q_no_overflow, !push || pop || count_reg != CNT_W'(DEPTH), "queue overflow")
    `TZKM_ASSERT(a_q_no_underflow, !pop || count_reg != '0, "queue underflow")
    `TZKM_ASSERT(a_q_count_range, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

FILE: rtl/core/tzkm_back.sv
// ----------------------------------------------------------------------------
// Touch zone key mapper back end
// Owner table, key mask update and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "touch_zone_key_mapper_top_macros.svh"

module tzkm_back
    import tzkm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_nonempty,
    input  wire evt_t             entry,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [KEY_W-1:0]      key_mask
);

    logic [NUM_CTRL-1:0] owner_valid_reg, owner_valid_next;
    logic [ID_W-1:0]     owner_finger_reg [NUM_CTRL];
    logic [KEY_W-1:0]    keys_reg, keys_next;
    logic [NUM_CTRL-1:0] own;
    logic [NUM_CTRL-1:0] take;
    logic                out_valid_reg;
    logic [KEY_W-1:0]    key_mask_reg;

    assign pop = q_nonempty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        for (int i = 0; i < NUM_CTRL; i++)
        begin
            own[i] = owner_valid_reg[i] && (owner_finger_reg[i] == entry.finger_id);
        end
    end

    always_comb
    begin
        keys_next        = keys_reg;
        owner_valid_next = owner_valid_reg;
        take             = '0;
        case (entry.func)
            FUNC_UP:
            begin
                for (int i = 0; i < NUM_CTRL; i++)
                begin
                    if (own[i])
                    begin
                        owner_valid_next[i] = 1'b0;
                        keys_next           = keys_next & ~CTRL_KEY[i];
                    end
                end
            end
            FUNC_DOWN, FUNC_MOTION:
            begin
                if (own[SLOT_DPAD])
                begin
                    keys_next = (keys_reg & ~KEY_DPAD) | entry.dir;
                end
                else if (own[SLOT_A])
                begin
                    keys_next = entry.a_in ? (keys_reg | KEY_A) : (keys_reg & ~KEY_A);
                end
                else if (own[SLOT_B])
                begin
                    keys_next = entry.b_in ? (keys_reg | KEY_B) : (keys_reg & ~KEY_B);
                end
                else if (|own[NUM_CTRL-1:SLOT_RECT0])
                begin
                    keys_next = keys_reg;
                end
                else if (entry.func == FUNC_DOWN)
                begin
                    if (entry.dpad_in)
                    begin
                        take[SLOT_DPAD] = 1'b1;
                        keys_next       = keys_reg | entry.dir;
                    end
                    else if (entry.a_in)
                    begin
                        take[SLOT_A] = 1'b1;
                        keys_next    = keys_reg | KEY_A;
                    end
                    else if (entry.b_in)
                    begin
                        take[SLOT_B] = 1'b1;
                        keys_next    = keys_reg | KEY_B;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_RECT; i++)
                        begin
                            if (entry.rect_hit[i])
                            begin
                                take[SLOT_RECT0 + i] = 1'b1;
                                keys_next = keys_next | CTRL_KEY[SLOT_RECT0 + i];
                            end
                        end
                    end
                end
            end
            FUNC_OTHER:
            begin
                keys_next = keys_reg;
            end
            default:
            begin
                keys_next = keys_reg;
            end
        endcase
        owner_valid_next = owner_valid_next | take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= '0;
            keys_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                owner_valid_reg <= owner_valid_next;
                keys_reg        <= keys_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_mask_reg <= keys_next;
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                if (take[i])
                begin
                    owner_finger_reg[i] <= entry.finger_id;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign key_mask  = key_mask_reg;

    `TZKM_ASSERT(a_dpad_keys_owned, (keys_reg & KEY_DPAD) == '0 || owner_valid_reg[SLOT_DPAD], "d-pad key without owner")
    `TZKM_ASSERT(a_a_key_owned, (keys_reg & KEY_A) == '0 || owner_valid_reg[SLOT_A], "A key without owner")
    `TZKM_ASSERT(a_b_key_owned, (keys_reg & KEY_B) == '0 || owner_valid_reg[SLOT_B], "B key without owner")
    `TZKM_ASSERT_NEXT(a_pop_loads_out, pop, out_valid_reg, "popped transaction not presented")

endmodule

`default_nettype wire

FILE: rtl/core/touch_zone_key_mapper_top.sv
// Path: front hit-test register stage, a QUEUE_DEPTH-entry queue, then the back
// owner-table update into the output register. Throughput: one event per cycle
// while out_stall stays low; a stalled output fills the queue and raises in_stall.
// Reset (rst_n, async, active low): owners released, held keys and out_valid zero,
// config at defaults; no clearing pass, the block accepts events right after reset.
// ----------------------------------------------------------------------------
// Touch zone key mapper top level
// Configuration registers and the front, queue and back instances.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_zone_key_mapper_top
    import tzkm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TZKM_QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [ID_W-1:0]       finger_id,
    input  wire logic [X_W-1:0]        x_pos,
    input  wire logic [Y_W-1:0]        y_pos,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [KEY_W-1:0]           key_mask,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t             cfg_reg, cfg_next;
    logic             push, pop;
    evt_t             push_data, pop_data;
    logic [CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE:   cfg_next.dead_zone   = cfg_data[DZ_W-1:0];
                CFG_DPAD_RADIUS: cfg_next.dpad_radius = cfg_data[RAD_W-1:0];
                CFG_A_RADIUS:    cfg_next.a_radius    = cfg_data[RAD_W-1:0];
                CFG_B_RADIUS:    cfg_next.b_radius    = cfg_data[RAD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone   <= DEAD_ZONE_RST;
            cfg_reg.dpad_radius <= DPAD_RADIUS_RST;
            cfg_reg.a_radius    <= A_RADIUS_RST;
            cfg_reg.b_radius    <= B_RADIUS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tzkm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .finger_id (finger_id),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .cfg       (cfg_reg),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    tzkm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    tzkm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_count != '0),
        .entry      (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_mask   (key_mask)
    );

endmodule

`default_nettype wire

FILE: verif/touch_zone_key_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch zone key mapper testbench
// Drives touch events through the valid/stall input channel and programs the
// four geometry registers between phases. A local model of the owner table
// and key mask predicts every result but the pinned rows. Directed events
// come first, then random gestures under several register settings, with
// random back-pressure, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_zone_key_mapper_top_tb;
    import tzkm_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0] f;
        logic [ID_W-1:0]   id;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              pinned;
        logic [KEY_W-1:0]  mask;
    } touch_row_t;

    localparam int SCRIPT_ROWS = 27;
    localparam int HOLD_CYCLES = 200;

    // pinned rows carry a typed-in key mask; the rest come from the model
    localparam touch_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{FUNC_OTHER,  16'h0000, 13'd0,    12'd0,    1'b1, 10'h000},
        '{FUNC_UP,     16'h0005, 13'd0,    12'd0,    1'b1, 10'h000},
        '{FUNC_MOTION, 16'h0005, 13'd864,  12'd2944, 1'b1, 10'h000},
        '{FUNC_DOWN,   16'h0001, 13'd864,  12'd2944, 1'b1, 10'h000},
        '{FUNC_MOTION, 16'h0001, 13'd1025, 12'd2944, 1'b1, KEY_RIGHT},
        '{FUNC_MOTION, 16'h0001, 13'd664,  12'd3144, 1'b0, 10'h000},
        '{FUNC_MOTION, 16'h0001, 13'd864,  12'd2644, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0002, 13'd864,  12'd3244, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0003, 13'd5856, 12'd2896, 1'b0, 10'h000},
        '{FUNC_MOTION, 16'h0003, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_MOTION, 16'h0003, 13'd6288, 12'd2896, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0020, 13'd5856, 12'd2700, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0004, 13'd5120, 12'd3232, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0006, 13'd2960, 12'd3440, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0007, 13'd2864, 12'd3760, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0008, 13'd1216, 12'd224,  1'b0, 10'h000},
        '{FUNC_DOWN,   16'hFFFF, 13'd5600, 12'd672,  1'b0, 10'h000},
        '{FUNC_DOWN,   16'h0006, 13'd5856, 12'd2896, 1'b0, 10'h000},
        '{FUNC_DOWN,   16'h1234, 13'd8191, 12'd4095, 1'b0, 10'h000},
        '{FUNC_UP,     16'h0002, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0003, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0020, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0004, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0006, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0007, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'h0008, 13'd0,    12'd0,    1'b0, 10'h000},
        '{FUNC_UP,     16'hFFFF, 13'd0,    12'd0,    1'b1, 10'h000}
    };

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
        CFG_DEAD_ZONE, CFG_DPAD_RADIUS, CFG_A_RADIUS, CFG_B_RADIUS
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [ID_W-1:0]       finger_id;
    logic [X_W-1:0]        x_pos;
    logic [Y_W-1:0]        y_pos;
    logic                  out_valid;
    logic                  out_stall;
    logic [KEY_W-1:0]      key_mask;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model state
    logic [DZ_W-1:0]  cfg_dead_zone = DEAD_ZONE_RST;
    logic [RAD_W-1:0] cfg_dpad_radius = DPAD_RADIUS_RST;
    logic [RAD_W-1:0] cfg_a_radius = A_RADIUS_RST;
    logic [RAD_W-1:0] cfg_b_radius = B_RADIUS_RST;
    logic [KEY_W-1:0] held_keys = '0;
    logic [ID_W-1:0]  owner_id [NUM_CTRL];
    logic             owner_on [NUM_CTRL];

    logic [KEY_W-1:0] pending_masks [$];
    logic [KEY_W-1:0] oldest_mask;
    int               mismatches = 0;
    bit               no_idle = 1'b0;
    bit               hold_go = 1'b0;

    touch_zone_key_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .finger_id (finger_id),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_mask  (key_mask),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit in_circle(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                     input logic [X_W-1:0] cx, input logic [Y_W-1:0] cy,
                                     input logic [RAD_W-1:0] r);
        longint dx;
        longint dy;
        dx = longint'(x) - longint'(cx);
        dy = longint'(y) - longint'(cy);
        return dx * dx + dy * dy <= longint'(r) * longint'(r);
    endfunction

    function automatic logic [KEY_W-1:0] dpad_dir(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
        int dx;
        int dy;
        int ax;
        int ay;
        dx = int'(x) - int'(DPAD_CX);
        dy = int'(y) - int'(DPAD_CY);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > int'(cfg_dead_zone) || ay > int'(cfg_dead_zone))
        begin
            if (ax >= ay)
                return (dx < 0) ? KEY_LEFT : KEY_RIGHT;
            return (dy < 0) ? KEY_UP : KEY_DOWN;
        end
        return '0;
    endfunction

    function automatic bit holds(input int s, input logic [ID_W-1:0] id);
        return owner_on[s] && owner_id[s] == id;
    endfunction

    function automatic void grab(input int s, input logic [ID_W-1:0] id);
        owner_on[s] = 1'b1;
        owner_id[s] = id;
    endfunction

    function automatic logic [KEY_W-1:0] next_key_mask(input logic [FUNC_W-1:0] f,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [X_W-1:0] x,
                                                       input logic [Y_W-1:0] y);
        bit a_hit;
        bit b_hit;
        bit rect_owner;
        a_hit = in_circle(x, y, A_CX, A_CY, cfg_a_radius);
        b_hit = in_circle(x, y, B_CX, B_CY, cfg_b_radius);
        rect_owner = 1'b0;
        for (int s = SLOT_RECT0; s < NUM_CTRL; s++)
            rect_owner |= holds(s, id);
        if (f == FUNC_UP)
        begin
            for (int s = 0; s < NUM_CTRL; s++)
            begin
                if (holds(s, id))
                begin
                    owner_on[s] = 1'b0;
                    held_keys &= ~CTRL_KEY[s];
                end
            end
        end
        else if (f == FUNC_DOWN || f == FUNC_MOTION)
        begin
            if (holds(SLOT_DPAD, id))
                held_keys = (held_keys & ~KEY_DPAD) | dpad_dir(x, y);
            else if (holds(SLOT_A, id))
                held_keys = a_hit ? (held_keys | KEY_A) : (held_keys & ~KEY_A);
            else if (holds(SLOT_B, id))
                held_keys = b_hit ? (held_keys | KEY_B) : (held_keys & ~KEY_B);
            else if (!rect_owner && f == FUNC_DOWN)
            begin
                if (in_circle(x, y, DPAD_CX, DPAD_CY, cfg_dpad_radius))
                begin
                    grab(SLOT_DPAD, id);
                    held_keys |= dpad_dir(x, y);
                end
                else if (a_hit)
                begin
                    grab(SLOT_A, id);
                    held_keys |= KEY_A;
                end
                else if (b_hit)
                begin
                    grab(SLOT_B, id);
                    held_keys |= KEY_B;
                end
                else
                begin
                    for (int k = 0; k < NUM_RECT; k++)
                    begin
                        if (x >= RECT_XLO[k] && x <= RECT_XHI[k] &&
                            y >= RECT_YLO[k] && y <= RECT_YHI[k])
                        begin
                            grab(SLOT_RECT0 + k, id);
                            held_keys |= CTRL_KEY[SLOT_RECT0 + k];
                            break;
                        end
                    end
                end
            end
        end
        return held_keys;
    endfunction

    task automatic offer_touch(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                               input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                               input logic pinned, input logic [KEY_W-1:0] mask);
        logic [KEY_W-1:0] predicted;
        in_valid  <= 1'b1;
        func      <= f;
        finger_id <= id;
        x_pos     <= x;
        y_pos     <= y;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_key_mask(f, id, x, y);
        pending_masks.push_back(pinned ? mask : predicted);
        while (!no_idle && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic random_touch();
        logic [FUNC_W-1:0] f;
        logic [ID_W-1:0]   id;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        int                pick;
        int                k;
        pick = $urandom_range(0, 99);
        f = (pick < 30) ? FUNC_DOWN : (pick < 65) ? FUNC_MOTION :
            (pick < 85) ? FUNC_UP : FUNC_OTHER;
        id = ($urandom_range(0, 99) < 90) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        pick = $urandom_range(0, 7);
        case (pick)
            0:
            begin
                x = X_W'($urandom_range(64, 1664));
                y = Y_W'($urandom_range(2144, 3744));
            end
            1:
            begin
                x = X_W'($urandom_range(5356, 6356));
                y = Y_W'($urandom_range(2396, 3396));
            end
            2:
            begin
                x = X_W'($urandom_range(4670, 5570));
                y = Y_W'($urandom_range(2782, 3682));
            end
            3, 4, 5, 6:
            begin
                k = pick - 3;
                x = X_W'($urandom_range(RECT_XLO[k] - 64, RECT_XHI[k] + 64));
                y = Y_W'($urandom_range(RECT_YLO[k] - 64, RECT_YHI[k] + 64));
            end
            default:
            begin
                x = X_W'($urandom_range(0, 8191));
                y = Y_W'($urandom_range(0, 4095));
            end
        endcase
        offer_touch(f, id, x, y, 1'b0, '0);
    endtask

    task automatic drain_masks();
        in_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic apply_config(input int unsigned dz, input int unsigned rd,
                                input int unsigned ra, input int unsigned rb);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[0] = CFG_DATA_W'(dz);
        vals[1] = CFG_DATA_W'(rd);
        vals[2] = CFG_DATA_W'(ra);
        vals[3] = CFG_DATA_W'(rb);
        drain_masks();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (REG_ORDER[i])
                CFG_DEAD_ZONE:   cfg_dead_zone = vals[i][DZ_W-1:0];
                CFG_DPAD_RADIUS: cfg_dpad_radius = vals[i][RAD_W-1:0];
                CFG_A_RADIUS:    cfg_a_radius = vals[i][RAD_W-1:0];
                CFG_B_RADIUS:    cfg_b_radius = vals[i][RAD_W-1:0];
                default:         ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_masks.size() == 0)
            begin
                $error("key_mask transaction with nothing pending: actual %h", key_mask);
                mismatches++;
            end
            else
            begin
                oldest_mask = pending_masks.pop_front();
                if (key_mask !== oldest_mask)
                begin
                    $error("key_mask expected %h actual %h", oldest_mask, key_mask);
                    mismatches++;
                end
            end
        end
    end

    // output side: random stall, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go = 1'b0;
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < 32);
        end
    end

    initial
    begin
        #2000000;
        $display("[touch_zone_key_mapper_top] ERROR");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < NUM_CTRL; s++)
        begin
            owner_id[s] = '0;
            owner_on[s] = 1'b0;
        end
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FUNC_OTHER;
        finger_id = '0;
        x_pos     = '0;
        y_pos     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEAD_ZONE;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            offer_touch(SCRIPT[i].f, SCRIPT[i].id, SCRIPT[i].x, SCRIPT[i].y,
                        SCRIPT[i].pinned, SCRIPT[i].mask);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: apply_config(0, 0, 0, 0);
                1: apply_config(1023, 2047, 2047, 2047);
                2: apply_config(DEAD_ZONE_RST, DPAD_RADIUS_RST, A_RADIUS_RST, B_RADIUS_RST);
                3: apply_config($urandom_range(0, 1023), $urandom_range(0, 2047),
                                $urandom_range(0, 2047), $urandom_range(0, 2047));
                default: apply_config($urandom_range(0, 400), $urandom_range(200, 900),
                                      $urandom_range(200, 900), $urandom_range(200, 900));
            endcase
            for (int n = 0; n < 200; n++)
            begin
                no_idle = (p == 2 && n < 120);
                if (p == 3 && n == 40)
                    hold_go = 1'b1;
                if (p == 4 && n == 100)
                    drain_masks();
                random_touch();
            end
        end

        drain_masks();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[touch_zone_key_mapper_top] OK");
        else
            $display("[touch_zone_key_mapper_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
